// ----- design/sap_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Server assignment policy package
// Shared widths, codes and structures for the server assignment policy unit.
// ----------------------------------------------------------------------------
package sap_pkg;

    localparam int NUM_SERVERS = 8;
    localparam int DEPTH_W     = 8;
    localparam int LOAD_W      = 8;
    localparam int SRV_IDX_W   = 3;
    localparam int MASK_W      = 8;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LOAD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LOAD  = CFG_IDX_W'(1);

    localparam logic [LOAD_W-1:0] HIGH_LOAD_RST = LOAD_W'(50);
    localparam logic [LOAD_W-1:0] LOW_LOAD_RST  = LOAD_W'(15);

    typedef enum logic [1:0] {
        KIND_BELOW_HIGH = 2'd0,
        KIND_ACTIVATED  = 2'd1,
        KIND_FALLBACK   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_0;
        logic [DEPTH_W-1:0] depth_1;
        logic [DEPTH_W-1:0] depth_2;
        logic [DEPTH_W-1:0] depth_3;
        logic [DEPTH_W-1:0] depth_4;
        logic [DEPTH_W-1:0] depth_5;
        logic [DEPTH_W-1:0] depth_6;
        logic [DEPTH_W-1:0] depth_7;
    } req_t;

    typedef struct packed {
        logic [SRV_IDX_W-1:0] server_index;
        logic [MASK_W-1:0]    active_mask;
        kind_t                choice_kind;
    } rsp_t;

    // Ripple between neighboring cells
    typedef struct packed {
        logic                 below_found;
        logic                 inact_found;
        logic                 min_valid;
        logic [DEPTH_W-1:0]   min_val;
        logic [SRV_IDX_W-1:0] min_idx;
    } chain_t;

    // Broadcast to every cell
    typedef struct packed {
        logic              load;
        logic              activate_en;
        logic [LOAD_W-1:0] high_load;
        logic [LOAD_W-1:0] low_load;
    } cell_ctl_t;

    // Per-cell selection flags
    typedef struct packed {
        logic pick_below;
        logic pick_act;
        logic active_next;
    } cell_pick_t;

endpackage
`default_nettype wire

// ----- design/sap_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sap_cfg_if;
    import sap_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- design/sap_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// One item per request, carrying the occupancy of every server.
// ----------------------------------------------------------------------------
interface sap_req_if;
    import sap_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/sap_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// One item per request: chosen server, new mask and kind of choice.
// ----------------------------------------------------------------------------
interface sap_rsp_if;
    import sap_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/sap_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Server cell
// Holds one active bit and ripples the selection state to its neighbor.
// ----------------------------------------------------------------------------
module sap_cell (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire  [sap_pkg::SRV_IDX_W-1:0] idx,
    input  wire  [sap_pkg::DEPTH_W-1:0]   depth,
    input  sap_pkg::cell_ctl_t            ctl,
    input  sap_pkg::chain_t               chain_in,
    output sap_pkg::chain_t               chain_out,
    output sap_pkg::cell_pick_t           pick,
    output logic                          active
);
    import sap_pkg::*;

    logic active_reg;
    logic active_next;
    logic keep;
    logic hit_below;
    logic is_free;
    logic take_min;

    always_comb
    begin
        keep      = active_reg && !(depth < ctl.low_load);
        hit_below = keep && (depth < ctl.high_load);
        is_free   = !keep;
        take_min  = !chain_in.min_valid || (depth < chain_in.min_val);

        chain_out.below_found = chain_in.below_found || hit_below;
        chain_out.inact_found = chain_in.inact_found || is_free;
        chain_out.min_valid   = 1'b1;
        chain_out.min_val     = take_min ? depth : chain_in.min_val;
        chain_out.min_idx     = take_min ? idx : chain_in.min_idx;

        pick.pick_below  = hit_below && !chain_in.below_found;
        pick.pick_act    = is_free && !chain_in.inact_found;
        pick.active_next = keep || (pick.pick_act && ctl.activate_en);
    end

    always_comb
    begin
        active_next = ctl.load ? pick.active_next : active_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    assign active = active_reg;

endmodule
`default_nettype wire

// ----- design/server_assignment_policy_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Server assignment policy unit
// Row of server cells deciding one assignment per request item.
// ----------------------------------------------------------------------------
// The result of an accepted request is registered in the output register, or in the skid while a result waits.
// Throughput: 1 item per cycle while the skid is empty; the mask update ripples combinationally through the cell row.
// A two-entry output stage (register plus skid) keeps input open while a result waits.
// Reset: all servers inactive, high_load 50, low_load 15, output stage empty.
module server_assignment_policy_unit (
    input  wire        clk,
    input  wire        rst_n,
    sap_cfg_if.sink    cfg,
    sap_req_if.sink    req,
    sap_rsp_if.source  rsp
);
    import sap_pkg::*;

    logic [LOAD_W-1:0] high_load_reg;
    logic [LOAD_W-1:0] high_load_next;
    logic [LOAD_W-1:0] low_load_reg;
    logic [LOAD_W-1:0] low_load_next;

    rsp_t out_reg;
    rsp_t out_next;
    logic out_valid_reg;
    logic out_valid_next;
    rsp_t skid_reg;
    rsp_t skid_next;
    logic skid_valid_reg;
    logic skid_valid_next;

    logic in_fire;
    logic out_fire;
    logic cfg_fire;

    logic [DEPTH_W-1:0]     depth     [8];
    chain_t                 chain     [NUM_SERVERS+1];
    cell_pick_t             picks     [NUM_SERVERS];
    cell_ctl_t              ctl;
    logic [NUM_SERVERS-1:0] active_q;
    logic [NUM_SERVERS-1:0] mask_new;
    logic [SRV_IDX_W-1:0]   below_idx;
    logic [SRV_IDX_W-1:0]   act_idx;
    rsp_t                   result;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign req.ready = !skid_valid_reg;
    assign in_fire   = req.valid && req.ready;
    assign out_fire  = out_valid_reg && rsp.ready;

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    assign depth[0] = req.data.depth_0;
    assign depth[1] = req.data.depth_1;
    assign depth[2] = req.data.depth_2;
    assign depth[3] = req.data.depth_3;
    assign depth[4] = req.data.depth_4;
    assign depth[5] = req.data.depth_5;
    assign depth[6] = req.data.depth_6;
    assign depth[7] = req.data.depth_7;

    always_comb
    begin
        high_load_next = high_load_reg;
        low_load_next  = low_load_reg;
        if (cfg_fire)
        begin
            case (cfg.index)
                CFG_HIGH_LOAD: high_load_next = LOAD_W'(cfg.data);
                CFG_LOW_LOAD:  low_load_next  = LOAD_W'(cfg.data);
                default:       ;
            endcase
        end
    end

    assign chain[0] = '0;

    // Step 2 result is known only at the end of the row
    assign ctl.load        = in_fire;
    assign ctl.activate_en = !chain[NUM_SERVERS].below_found;
    assign ctl.high_load   = high_load_reg;
    assign ctl.low_load    = low_load_reg;

    for (genvar i = 0; i < NUM_SERVERS; i++)
    begin : g_cell
        sap_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (SRV_IDX_W'(i)),
            .depth     (depth[i]),
            .ctl       (ctl),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .pick      (picks[i]),
            .active    (active_q[i])
        );
        assign mask_new[i] = picks[i].active_next;
    end

    always_comb
    begin
        below_idx = '0;
        act_idx   = '0;
        for (int i = 0; i < NUM_SERVERS; i++)
        begin
            below_idx = below_idx | (picks[i].pick_below ? SRV_IDX_W'(i) : '0);
            act_idx   = act_idx | (picks[i].pick_act ? SRV_IDX_W'(i) : '0);
        end

        result.active_mask = MASK_W'(mask_new);
        if (chain[NUM_SERVERS].below_found)
        begin
            result.server_index = below_idx;
            result.choice_kind  = KIND_BELOW_HIGH;
        end
        else if (chain[NUM_SERVERS].inact_found)
        begin
            result.server_index = act_idx;
            result.choice_kind  = KIND_ACTIVATED;
        end
        else
        begin
            result.server_index = chain[NUM_SERVERS].min_idx;
            result.choice_kind  = KIND_FALLBACK;
        end
    end

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_load_reg  <= HIGH_LOAD_RST;
            low_load_reg   <= LOW_LOAD_RST;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            high_load_reg  <= high_load_next;
            low_load_reg   <= low_load_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    a_mask_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !out_valid_reg) |=> (out_reg.active_mask == MASK_W'(active_q)))
        else $error("reported mask differs from cell state");

    a_chosen_is_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_reg.choice_kind == KIND_BELOW_HIGH)
            || (out_reg.choice_kind == KIND_ACTIVATED)))
        |-> out_reg.active_mask[out_reg.server_index])
        else $error("chosen server not active in reported mask");

    a_fallback_all_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.choice_kind == KIND_FALLBACK))
        |-> (&out_reg.active_mask[NUM_SERVERS-1:0]))
        else $error("fallback taken with an inactive server");

endmodule
`default_nettype wire

// ----- dv/sap_assign_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Server assignment checker
// Follows register writes and requests, computes the server choice and mask
// each request should produce, and compares every result field by field.
// ----------------------------------------------------------------------------
module sap_assign_check (
    input  logic clk,
    input  logic rst_n,
    sap_cfg_if   cfg,
    sap_req_if   req,
    sap_rsp_if   rsp,
    output int   errors,
    output int   pending,
    output int   below_cnt,
    output int   activated_cnt,
    output int   fallback_cnt
);
    import sap_pkg::*;

    logic [LOAD_W-1:0] high_load;
    logic [LOAD_W-1:0] low_load;
    logic [MASK_W-1:0] active_set;
    rsp_t              choice_q[$];
    int                err_total;
    int                below_total;
    int                act_total;
    int                fb_total;

    function automatic rsp_t assign_server(input req_t r, input logic [MASK_W-1:0] mask_in,
                                           input logic [LOAD_W-1:0] hi,
                                           input logic [LOAD_W-1:0] lo);
        logic [DEPTH_W-1:0] dep [8];
        logic [MASK_W-1:0]  mask;
        logic               found;
        int                 pick;
        kind_t              kind;
        rsp_t               res;
        {dep[0], dep[1], dep[2], dep[3], dep[4], dep[5], dep[6], dep[7]} = r;
        mask  = '0;
        found = 1'b0;
        pick  = 0;
        kind  = KIND_FALLBACK;
        for (int i = 0; i < NUM_SERVERS; i++)
        begin
            mask[i] = mask_in[i] && !(dep[i] < lo);
        end
        for (int i = 0; i < NUM_SERVERS; i++)
        begin
            if (!found && mask[i] && dep[i] < hi)
            begin
                pick  = i;
                kind  = KIND_BELOW_HIGH;
                found = 1'b1;
            end
        end
        for (int i = 0; i < NUM_SERVERS; i++)
        begin
            if (!found && !mask[i])
            begin
                mask[i] = 1'b1;
                pick    = i;
                kind    = KIND_ACTIVATED;
                found   = 1'b1;
            end
        end
        if (!found)
        begin
            pick = 0;
            for (int i = 1; i < NUM_SERVERS; i++)
            begin
                if (dep[i] < dep[pick])
                    pick = i;
            end
            kind = KIND_FALLBACK;
        end
        res.server_index = SRV_IDX_W'(pick);
        res.active_mask  = mask;
        res.choice_kind  = kind;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        rsp_t got;
        if (!rst_n)
        begin
            high_load   = HIGH_LOAD_RST;
            low_load    = LOW_LOAD_RST;
            active_set  = '0;
            choice_q.delete();
            err_total   = 0;
            below_total = 0;
            act_total   = 0;
            fb_total    = 0;
            errors        <= 0;
            pending       <= 0;
            below_cnt     <= 0;
            activated_cnt <= 0;
            fallback_cnt  <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_HIGH_LOAD)
                    high_load = cfg.data;
                else if (cfg.index == CFG_LOW_LOAD)
                    low_load = cfg.data;
            end
            if (rsp.valid && rsp.ready)
            begin
                got = rsp.data;
                case (got.choice_kind)
                    KIND_BELOW_HIGH: below_total++;
                    KIND_ACTIVATED:  act_total++;
                    default:         fb_total++;
                endcase
                if (choice_q.size() == 0)
                begin
                    $error("result item with no request outstanding");
                    err_total++;
                end
                else
                begin
                    want = choice_q.pop_front();
                    if (got.server_index !== want.server_index)
                    begin
                        $error("server_index: expected %0d, actual %0d",
                               want.server_index, got.server_index);
                        err_total++;
                    end
                    if (got.active_mask !== want.active_mask)
                    begin
                        $error("active_mask: expected 0x%02h, actual 0x%02h",
                               want.active_mask, got.active_mask);
                        err_total++;
                    end
                    if (got.choice_kind !== want.choice_kind)
                    begin
                        $error("choice_kind: expected %0d, actual %0d",
                               want.choice_kind, got.choice_kind);
                        err_total++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                want       = assign_server(req.data, active_set, high_load, low_load);
                active_set = want.active_mask;
                choice_q.push_back(want);
            end
            errors        <= err_total;
            pending       <= choice_q.size();
            below_cnt     <= below_total;
            activated_cnt <= act_total;
            fallback_cnt  <= fb_total;
        end
    end

endmodule

// ----- dv/tb_server_assignment_policy_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Server assignment policy unit testbench
// Drives directed and randomized occupancy requests under a series of
// threshold settings, with random gaps and stalls on both channels and a
// long result hold-off; the checker module scores every result.
// ----------------------------------------------------------------------------
module tb_server_assignment_policy_unit;
    import sap_pkg::*;

    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 145;
    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 500000;

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   errors;
    int   pending;
    int   below_cnt;
    int   activated_cnt;
    int   fallback_cnt;
    int   sent_cnt;
    int   settings_cnt;
    bit   req_steady;

    logic [LOAD_W-1:0] cur_hi;
    logic [LOAD_W-1:0] cur_lo;

    sap_cfg_if cfg_ch ();
    sap_req_if req_ch ();
    sap_rsp_if rsp_ch ();

    server_assignment_policy_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sap_assign_check assign_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_ch),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .errors        (errors),
        .pending       (pending),
        .below_cnt     (below_cnt),
        .activated_cnt (activated_cnt),
        .fallback_cnt  (fallback_cnt)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic req_t mk_req(input int d0, input int d1, input int d2, input int d3,
                                    input int d4, input int d5, input int d6, input int d7);
        return {DEPTH_W'(d0), DEPTH_W'(d1), DEPTH_W'(d2), DEPTH_W'(d3),
                DEPTH_W'(d4), DEPTH_W'(d5), DEPTH_W'(d6), DEPTH_W'(d7)};
    endfunction

    // Occupancies cluster around the thresholds; some items load every server
    function automatic req_t rand_req(input logic [LOAD_W-1:0] hi, input logic [LOAD_W-1:0] lo);
        logic [DEPTH_W-1:0] d [8];
        bit                 heavy;
        int                 v;
        heavy = ($urandom_range(0, 6) == 0);
        for (int i = 0; i < 8; i++)
        begin
            if (heavy)
                v = $urandom_range(int'(hi), 255);
            else
            begin
                case ($urandom_range(0, 9))
                    4, 5:    v = int'(lo) + int'($urandom_range(0, 4)) - 2;
                    6, 7:    v = int'(hi) + int'($urandom_range(0, 4)) - 2;
                    8:       v = 0;
                    9:       v = 255;
                    default: v = $urandom_range(0, 255);
                endcase
            end
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            d[i] = DEPTH_W'(v);
        end
        return {d[0], d[1], d[2], d[3], d[4], d[5], d[6], d[7]};
    endfunction

    task automatic send_req(input req_t r);
        int gap;
        if ($urandom_range(0, 49) == 0)
            req_steady = !req_steady;
        gap = req_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge clk); while (!req_ch.ready);
        sent_cnt++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Both thresholds, then a write to an unmapped index
    task automatic write_regs(input logic [LOAD_W-1:0] hi, input logic [LOAD_W-1:0] lo);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx[0] = CFG_HIGH_LOAD;
        val[0] = hi;
        idx[1] = CFG_LOW_LOAD;
        val[1] = lo;
        idx[2] = CFG_LOW_LOAD + CFG_IDX_W'(1 + $urandom_range(0, 253));
        val[2] = CFG_DATA_W'($urandom_range(0, 255));
        for (int k = 0; k < 3; k++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[k];
            cfg_ch.data  <= val[k];
            do @(posedge clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        cur_hi = hi;
        cur_lo = lo;
        settings_cnt++;
    endtask

    initial
    begin
        int stall;
        int taken;
        bit steady;
        rsp_ch.ready <= 1'b0;
        taken  = 0;
        steady = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                steady = !steady;
            stall = steady ? 0 : $urandom_range(0, 16);
            if (taken == 300 || taken == 900)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            taken++;
        end
    end

    initial
    begin
        int hi_set [PHASES];
        int lo_set [PHASES];
        hi_set = '{50, 255, 0, 0, 255, 10, 80, 0, 50};
        lo_set = '{15, 0, 255, 0, 255, 200, 20, 0, 15};
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        sent_cnt     = 0;
        settings_cnt = 1;
        req_steady   = 1'b0;
        cur_hi       = HIGH_LOAD_RST;
        cur_lo       = LOW_LOAD_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_req(mk_req(0, 0, 0, 0, 0, 0, 0, 0));
        repeat (7) send_req(mk_req(255, 255, 255, 255, 255, 255, 255, 255));
        send_req(mk_req(255, 255, 255, 255, 255, 255, 255, 255));
        send_req(mk_req(200, 180, 90, 90, 255, 255, 255, 255));
        send_req(mk_req(100, 100, 100, 100, 100, 30, 100, 100));
        send_req(mk_req(100, 100, 100, 0, 100, 100, 100, 100));
        send_req(mk_req(49, 50, 51, 15, 14, 16, 255, 0));
        send_req(mk_req(14, 14, 14, 14, 14, 14, 14, 14));
        send_req(mk_req(170, 85, 170, 85, 170, 85, 170, 85));
        send_req(mk_req(85, 170, 85, 170, 85, 170, 85, 170));
        send_req(mk_req(60, 60, 60, 60, 60, 60, 60, 60));
        send_req(mk_req(255, 254, 253, 252, 251, 250, 249, 249));
        drain();
        write_regs(LOAD_W'(10), LOAD_W'(200));
        repeat (3) send_req(mk_req(255, 255, 255, 255, 255, 255, 255, 255));
        send_req(mk_req(100, 100, 100, 100, 100, 100, 100, 100));
        send_req(mk_req(5, 5, 5, 5, 5, 5, 5, 5));
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 7)
                write_regs(LOAD_W'($urandom_range(0, 255)), LOAD_W'($urandom_range(0, 255)));
            else
                write_regs(LOAD_W'(hi_set[p]), LOAD_W'(lo_set[p]));
            repeat (ITEMS_PER_PHASE) send_req(rand_req(cur_hi, cur_lo));
            drain();
        end
        repeat (8) @(posedge clk);

        $display("Sent %0d requests under %0d threshold settings, crossed and extreme included.",
                 sent_cnt, settings_cnt);
        $display("Choices: %0d active below high, %0d newly activated, %0d least-loaded fallback.",
                 below_cnt, activated_cnt, fallback_cnt);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- server_assignment_policy_unit.f -----
design/sap_pkg.sv
design/sap_cfg_if.sv
design/sap_req_if.sv
design/sap_rsp_if.sv
design/sap_cell.sv
design/server_assignment_policy_unit.sv
dv/sap_assign_check.sv
dv/tb_server_assignment_policy_unit.sv
